FILE: hdl/array_linked_list_manager_macros.svh
// Assertion macros shared by the list manager RTL.
// Define NO_ASSERTIONS to compile every assertion away; no other dependencies.
`ifndef ARRAY_LINKED_LIST_MANAGER_MACROS_SVH
`define ARRAY_LINKED_LIST_MANAGER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is asserted.
`define ALLM_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ALLM_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ALLM_ASSERT_IMP(label, clk, rstn, ante, cons, msg)
`define ALLM_ASSERT_NXT(label, clk, rstn, ante, cons, msg)

`endif

`endif

FILE: hdl/allm_pkg.sv
// Constants, codes and helper functions of the array linked list manager.
// No dependencies; used by array_linked_list_manager.
package allm_pkg;

    localparam int SLOTS  = 64;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int DATA_W = 32;
    localparam int CMD_W  = 2;
    localparam int STAT_W = 2;
    localparam int ERR_W  = 2;

    localparam int IN_W      = CMD_W + SLOT_W + DATA_W;
    localparam int OUT_RAW_W = SLOT_W + DATA_W + STAT_W + ERR_W;
    localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_BAD  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

    localparam int ERR_BAD_BIT  = 0;
    localparam int ERR_FULL_BIT = 1;

    // Next link of a slot that was never written: the free chain order after
    // reset, with the sentinel and the last slot pointing to slot 0.
    function automatic logic [SLOT_W-1:0] reset_next(input logic [SLOT_W-1:0] idx);
        if (idx == '0 || idx == SLOT_W'(SLOTS - 1)) begin
            return '0;
        end else begin
            return idx + 1'b1;
        end
    endfunction

endpackage

FILE: hdl/array_linked_list_manager.sv
// Top level of the array linked list manager: sequencer, link and data memories.
// Depends on allm_pkg and array_linked_list_manager_macros.svh.
//
//  Channel  | Direction | Handshake          | Word
//  ---------+-----------+--------------------+-------------------------------------
//  s_       | in        | s_tvalid/s_tready  | cmd, slot_index, write_value
//  m_       | out       | m_tvalid/m_tready  | new_slot, read_value, status, errors
//  cfg_     | in        | cfg_wr_en          | poison word for free slots
//
// One word at a time. Insert, delete and read step through their own states to
// ST_OUT, rejects and unknown commands go straight there. The single link write
// port sets the insert and delete steps: an insert makes three link writes, a delete three.
// Per-entry valid bits give the reset contents, no sweep.
// A result waiting in the output register holds the sequencer in its last state.
`include "array_linked_list_manager_macros.svh"

module array_linked_list_manager (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [allm_pkg::DATA_W-1:0] cfg_wr_data,   // poison word
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [allm_pkg::IN_W-1:0]   s_tdata,       // cmd, slot_index, write_value
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [allm_pkg::OUT_W-1:0]  m_tdata        // new_slot, read_value, status,
                                                       // error_flags, zero pad
);

    localparam int SW = allm_pkg::SLOT_W;
    localparam int DW = allm_pkg::DATA_W;
    localparam int N  = allm_pkg::SLOTS;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_INS1 = 4'd1;
    localparam logic [3:0] ST_INS2 = 4'd2;
    localparam logic [3:0] ST_INS3 = 4'd3;
    localparam logic [3:0] ST_INS4 = 4'd4;
    localparam logic [3:0] ST_DEL1 = 4'd5;
    localparam logic [3:0] ST_DEL2 = 4'd6;
    localparam logic [3:0] ST_DEL3 = 4'd7;
    localparam logic [3:0] ST_RD1  = 4'd8;
    localparam logic [3:0] ST_OUT  = 4'd9;

    // Input word fields.
    logic [allm_pkg::CMD_W-1:0] in_cmd;
    logic [SW-1:0]              in_slot;
    logic [DW-1:0]              in_wval;

    assign in_cmd  = s_tdata[allm_pkg::CMD_W-1:0];
    assign in_slot = s_tdata[allm_pkg::CMD_W +: SW];
    assign in_wval = s_tdata[allm_pkg::CMD_W + SW +: DW];

    // Control state.
    logic [3:0]                 state_reg, state_next;
    logic [SW-1:0]              free_head_reg, free_head_next;
    logic [allm_pkg::ERR_W-1:0] sticky_reg, sticky_next;
    logic [N-1:0]               used_reg, used_next;
    logic [DW-1:0]              poison_reg;
    logic                       m_valid_reg, m_valid_next;
    logic [N-1:0]               nvld_reg, pvld_reg, dvld_reg;

    // Per-command payload.
    logic [SW-1:0]               slot_reg, slot_next;
    logic [SW-1:0]               new_reg, new_next;
    logic [DW-1:0]               wval_reg, wval_next;
    logic [SW-1:0]               nxt_cap_reg, nxt_cap_next;
    logic [SW-1:0]               prv_cap_reg, prv_cap_next;
    logic [SW-1:0]               res_slot_reg, res_slot_next;
    logic [DW-1:0]               res_value_reg, res_value_next;
    logic [allm_pkg::STAT_W-1:0] res_status_reg, res_status_next;
    logic [allm_pkg::OUT_W-1:0]  m_data_reg, m_data_next;

    // Link memory: next link in the upper field, prev link in the lower one.
    logic [2*SW-1:0] link_mem [N];
    logic [2*SW-1:0] lk_q_reg;
    logic            lk_nv_q_reg, lk_pv_q_reg;
    logic [SW-1:0]   lk_addr_q_reg;
    logic [SW-1:0]   lk_rd_addr;
    logic            lk_we_n, lk_we_p;
    logic [SW-1:0]   lk_wr_addr, lk_wr_nxt, lk_wr_prv;
    logic [SW-1:0]   lk_next_eff, lk_prev_eff;

    // Data memory.
    logic [DW-1:0] data_mem [N];
    logic [DW-1:0] dm_q_reg;
    logic          dm_v_q_reg;
    logic          dm_we;
    logic [SW-1:0] dm_wr_addr;
    logic [DW-1:0] dm_wr_data;
    logic [DW-1:0] dm_eff;

    logic accept, out_free, used_at;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign used_at  = used_reg[in_slot];
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Entries never written read as their reset contents.
    assign lk_next_eff = lk_nv_q_reg ? lk_q_reg[2*SW-1:SW] : allm_pkg::reset_next(lk_addr_q_reg);
    assign lk_prev_eff = lk_pv_q_reg ? lk_q_reg[SW-1:0] : '0;
    assign dm_eff      = dm_v_q_reg ? dm_q_reg : '0;

    always_comb begin
        state_next      = state_reg;
        free_head_next  = free_head_reg;
        sticky_next     = sticky_reg;
        used_next       = used_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        slot_next       = slot_reg;
        new_next        = new_reg;
        wval_next       = wval_reg;
        nxt_cap_next    = nxt_cap_reg;
        prv_cap_next    = prv_cap_reg;
        res_slot_next   = res_slot_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        m_data_next     = m_data_reg;
        lk_rd_addr      = in_slot;
        lk_we_n         = 1'b0;
        lk_we_p         = 1'b0;
        lk_wr_addr      = slot_reg;
        lk_wr_nxt       = '0;
        lk_wr_prv       = '0;
        dm_we           = 1'b0;
        dm_wr_addr      = slot_reg;
        dm_wr_data      = wval_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    slot_next       = in_slot;
                    new_next        = free_head_reg;
                    wval_next       = in_wval;
                    res_slot_next   = '0;
                    res_value_next  = '0;
                    res_status_next = allm_pkg::STAT_OK;
                    state_next      = ST_OUT;
                    case (in_cmd)
                        allm_pkg::CMD_INSERT: begin
                            if (!used_at) begin
                                res_status_next = allm_pkg::STAT_BAD;
                            end else if (free_head_reg == '0) begin
                                res_status_next = allm_pkg::STAT_FULL;
                            end else begin
                                state_next = ST_INS1;
                            end
                        end
                        allm_pkg::CMD_DELETE: begin
                            if (in_slot == '0 || !used_at) begin
                                res_status_next = allm_pkg::STAT_BAD;
                            end else begin
                                state_next = ST_DEL1;
                            end
                        end
                        allm_pkg::CMD_READ: begin
                            state_next = ST_RD1;
                        end
                        default: begin
                            state_next = ST_OUT;
                        end
                    endcase
                    if (res_status_next == allm_pkg::STAT_BAD) begin
                        sticky_next[allm_pkg::ERR_BAD_BIT] = 1'b1;
                    end
                    if (res_status_next == allm_pkg::STAT_FULL) begin
                        sticky_next[allm_pkg::ERR_FULL_BIT] = 1'b1;
                    end
                end
            end
            ST_INS1: begin
                // Successor of the anchor arrives; fetch the new slot's link.
                nxt_cap_next = lk_next_eff;
                lk_rd_addr   = new_reg;
                state_next   = ST_INS2;
            end
            ST_INS2: begin
                free_head_next     = lk_next_eff;
                lk_we_n            = 1'b1;
                lk_we_p            = 1'b1;
                lk_wr_addr         = new_reg;
                lk_wr_nxt          = nxt_cap_reg;
                lk_wr_prv          = slot_reg;
                dm_we              = 1'b1;
                dm_wr_addr         = new_reg;
                dm_wr_data         = wval_reg;
                used_next[new_reg] = 1'b1;
                state_next         = ST_INS3;
            end
            ST_INS3: begin
                lk_we_n    = 1'b1;
                lk_wr_addr = slot_reg;
                lk_wr_nxt  = new_reg;
                state_next = ST_INS4;
            end
            ST_INS4: begin
                lk_we_p       = 1'b1;
                lk_wr_addr    = nxt_cap_reg;
                lk_wr_prv     = new_reg;
                res_slot_next = new_reg;
                state_next    = ST_OUT;
            end
            ST_DEL1: begin
                // Neighbors of the victim arrive; relink the successor first.
                prv_cap_next        = lk_prev_eff;
                nxt_cap_next        = lk_next_eff;
                lk_we_p             = 1'b1;
                lk_wr_addr          = lk_next_eff;
                lk_wr_prv           = lk_prev_eff;
                dm_we               = 1'b1;
                dm_wr_addr          = slot_reg;
                dm_wr_data          = poison_reg;
                used_next[slot_reg] = 1'b0;
                state_next          = ST_DEL2;
            end
            ST_DEL2: begin
                lk_we_n    = 1'b1;
                lk_wr_addr = prv_cap_reg;
                lk_wr_nxt  = nxt_cap_reg;
                state_next = ST_DEL3;
            end
            ST_DEL3: begin
                lk_we_n        = 1'b1;
                lk_we_p        = 1'b1;
                lk_wr_addr     = slot_reg;
                lk_wr_nxt      = free_head_reg;
                lk_wr_prv      = '0;
                free_head_next = slot_reg;
                state_next     = ST_OUT;
            end
            ST_RD1: begin
                res_value_next = dm_eff;
                state_next     = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = allm_pkg::OUT_W'({sticky_reg, res_status_reg,
                                                     res_value_reg, res_slot_reg});
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            free_head_reg <= SW'(1);
            sticky_reg    <= '0;
            used_reg      <= N'(1);
            poison_reg    <= '0;
            m_valid_reg   <= 1'b0;
            nvld_reg      <= '0;
            pvld_reg      <= '0;
            dvld_reg      <= '0;
        end else begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            sticky_reg    <= sticky_next;
            used_reg      <= used_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_wr_en) begin
                poison_reg <= cfg_wr_data;
            end
            if (lk_we_n) begin
                nvld_reg[lk_wr_addr] <= 1'b1;
            end
            if (lk_we_p) begin
                pvld_reg[lk_wr_addr] <= 1'b1;
            end
            if (dm_we) begin
                dvld_reg[dm_wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        slot_reg       <= slot_next;
        new_reg        <= new_next;
        wval_reg       <= wval_next;
        nxt_cap_reg    <= nxt_cap_next;
        prv_cap_reg    <= prv_cap_next;
        res_slot_reg   <= res_slot_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        m_data_reg     <= m_data_next;
    end

    // The sequencer never reads an entry in the cycle it writes it.
    always_ff @(posedge aclk) begin
        if (lk_we_n) begin
            link_mem[lk_wr_addr][2*SW-1:SW] <= lk_wr_nxt;
        end
        if (lk_we_p) begin
            link_mem[lk_wr_addr][SW-1:0] <= lk_wr_prv;
        end
        lk_q_reg      <= link_mem[lk_rd_addr];
        lk_nv_q_reg   <= nvld_reg[lk_rd_addr];
        lk_pv_q_reg   <= pvld_reg[lk_rd_addr];
        lk_addr_q_reg <= lk_rd_addr;
    end

    always_ff @(posedge aclk) begin
        if (dm_we) begin
            data_mem[dm_wr_addr] <= dm_wr_data;
        end
        dm_q_reg   <= data_mem[in_slot];
        dm_v_q_reg <= dvld_reg[in_slot];
    end

    `ALLM_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, accept, state_reg != ST_IDLE, "accepted word did not start a command")
    `ALLM_ASSERT_IMP(a_sentinel_used, aclk, aresetn, 1'b1, used_reg[0], "sentinel slot marked free")
    `ALLM_ASSERT_IMP(a_full_matches_head, aclk, aresetn, state_reg == ST_OUT && res_status_reg == allm_pkg::STAT_FULL, free_head_reg == '0, "full status with free slots left")
    `ALLM_ASSERT_NXT(a_sticky_holds, aclk, aresetn, 1'b1, (sticky_reg & $past(sticky_reg)) == $past(sticky_reg), "sticky error bit cleared")
    `ALLM_ASSERT_IMP(a_insert_takes_free, aclk, aresetn, state_reg == ST_INS2, !used_reg[new_reg] && new_reg != '0, "insert took a used slot")

endmodule
